// File: rtl/core/bdq_pkg.sv
// shared types, widths and codes of the bounded deque
package bdq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int QUEUE_DEF = 2;

	localparam int CMD_W = 2;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WALK       = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_WALK
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic signed [VAL_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic        [CMD_W-1:0] command;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] data_out;
		logic        [ST_W-1:0]  status;
		logic        [CNT_W-1:0] entries;
		logic                    last;
	} rsp_t;

endpackage

// File: rtl/core/bdq_stream_if.sv
// valid/ready stream channel carrying one payload per transfer
interface bdq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/bounded_deque_head_push.sv
// top level of the bounded deque: front stage, operation queue, back stage
// a push result passes the front register, the operation queue and the result register;
// a pop also passes the store's single registered read port. Throughput: one push per cycle
// while results are taken; a pop or walk holds the back stage until its last result is out
// reset: arst_n clears pointers, count, walk position and all valid flags, giving an empty list
// element store contents are undefined until written; no clearing pass is run
module bounded_deque_head_push #(
	parameter int DEPTH         = bdq_pkg::DEPTH_DEF,
	parameter int QUEUE_ENTRIES = bdq_pkg::QUEUE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bdq_stream_if.sink   request,
	bdq_stream_if.source response
);
	import bdq_pkg::*;

	// front to queue transfer
	logic front_valid;
	op_t  front_op;
	logic front_ready;

	// queue to back transfer
	logic back_valid;
	op_t  back_op;
	logic back_ready;

	// request decode and input register
	bdq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.op_valid (front_valid),
		.op       (front_op),
		.op_ready (front_ready)
	);

	// decouples the request side from a back stage busy with a walk or a stalled result
	bdq_queue #(
		.ENTRIES (QUEUE_ENTRIES)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_op     (front_op),
		.in_ready  (front_ready),
		.out_valid (back_valid),
		.out_op    (back_op),
		.out_ready (back_ready)
	);

	// ring buffer, walk sequencer and result register
	bdq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (back_valid),
		.op       (back_op),
		.op_ready (back_ready),
		.response (response)
	);
endmodule

// File: rtl/core/bdq_front.sv
// front stage: takes requests, classifies the command into an operation
module bdq_front (
	input  logic          clk,
	input  logic          arst_n,
	bdq_stream_if.sink    request,
	output logic          op_valid,
	output bdq_pkg::op_t  op,
	input  logic          op_ready
);
	import bdq_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_dec;

	always_comb begin
		op_dec.value = '0;
		unique case (request.payload.command)
			CMD_PUSH_FRONT: begin
				op_dec.kind  = OP_PUSH;
				op_dec.value = request.payload.value;
			end
			CMD_POP_FRONT: op_dec.kind = OP_POP_FRONT;
			CMD_POP_BACK:  op_dec.kind = OP_POP_BACK;
			CMD_WALK:      op_dec.kind = OP_WALK;
		endcase
	end

	assign request.ready = !valid_s1 || op_ready;
	assign op_valid      = valid_s1;
	assign op            = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.valid && request.ready) begin
			valid_s1 <= 1'b1;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			op_s1 <= op_dec;
		end
	end
endmodule

// File: rtl/core/bdq_queue.sv
// short operation queue between the front and back stages
module bdq_queue #(
	parameter int ENTRIES = bdq_pkg::QUEUE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  bdq_pkg::op_t in_op,
	output logic         in_ready,
	output logic         out_valid,
	output bdq_pkg::op_t out_op,
	input  logic         out_ready
);
	import bdq_pkg::*;

	localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LVL_W = $clog2(ENTRIES + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(ENTRIES - 1);
	localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(ENTRIES);

	op_t              slot_q [ENTRIES];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             push;
	logic             pop;

	assign in_ready  = level_q != FULL_LVL;
	assign out_valid = level_q != '0;
	assign out_op    = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end
endmodule

// File: rtl/core/bdq_back.sv
// back stage: ring-buffer store, pointers, walk sequencer and result register
module bdq_back #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	input  bdq_pkg::op_t op,
	output logic         op_ready,
	bdq_stream_if.source response
);
	import bdq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_WALK = 3'b100
	} back_state_t;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;

	back_state_t      state_q,    state_d;
	logic [PTR_W-1:0] front_q,    front_d;
	logic [CNT_W-1:0] count_q,    count_d;
	logic [CNT_W-1:0] walk_idx_q, walk_idx_d;
	logic [PTR_W-1:0] walk_ptr_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             out_free;
	logic             take;
	logic             emit;
	rsp_t             emit_rsp;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             wr_en;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] front_inc;
	logic [PTR_W-1:0] walk_next;
	logic [CNT_W-1:0] cnt_m1;
	logic [PTR_W:0]   back_sum;
	logic [PTR_W-1:0] back_slot;
	logic             is_empty;
	logic             is_full;
	logic             walk_last;

	assign out_free  = !out_valid_q || response.ready;
	assign op_ready  = (state_q == S_IDLE) && out_free;
	assign take      = op_ready && op_valid;

	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - PTR_W'(1);
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + PTR_W'(1);
	assign walk_next = (walk_ptr_q == LAST_SLOT) ? '0 : walk_ptr_q + PTR_W'(1);
	assign cnt_m1    = count_q - CNT_W'(1);
	// back slot: front plus count minus one, folded once into the ring
	assign back_sum  = {1'b0, front_q} + {1'b0, cnt_m1[PTR_W-1:0]};
	assign back_slot = (back_sum >= DEPTH_X) ? PTR_W'(back_sum - DEPTH_X)
	                                         : back_sum[PTR_W-1:0];
	assign is_empty  = count_q == '0;
	assign is_full   = count_q == FULL_CNT;
	assign walk_last = (walk_idx_q + CNT_W'(1)) == count_q;
	assign wr_en     = take && (op.kind == OP_PUSH) && !is_full;

	always_comb begin
		state_d           = state_q;
		front_d           = front_q;
		count_d           = count_q;
		walk_idx_d        = walk_idx_q;
		emit              = 1'b0;
		emit_rsp.data_out = '0;
		emit_rsp.status   = ST_OK;
		emit_rsp.entries  = count_q;
		emit_rsp.last     = 1'b1;
		rd_en             = 1'b0;
		rd_addr           = front_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (op.kind) inside
						OP_PUSH: begin
							emit = 1'b1;
							if (is_full) begin
								emit_rsp.status = ST_FULL;
							end else begin
								front_d          = front_dec;
								count_d          = count_q + CNT_W'(1);
								emit_rsp.entries = count_q + CNT_W'(1);
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (is_empty) begin
								emit            = 1'b1;
								emit_rsp.status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								count_d = cnt_m1;
								state_d = S_POP;
								if (op.kind == OP_POP_FRONT) begin
									front_d = front_inc;
								end else begin
									rd_addr = back_slot;
								end
							end
						end
						OP_WALK: begin
							if (is_empty) begin
								emit            = 1'b1;
								emit_rsp.status = ST_EMPTY;
							end else begin
								rd_en      = 1'b1;
								walk_idx_d = '0;
								state_d    = S_WALK;
							end
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					emit              = 1'b1;
					emit_rsp.data_out = rd_data_q;
					state_d           = S_IDLE;
				end
			end
			S_WALK: begin
				if (out_free) begin
					emit              = 1'b1;
					emit_rsp.data_out = rd_data_q;
					emit_rsp.last     = walk_last;
					if (walk_last) begin
						walk_idx_d = '0;
						state_d    = S_IDLE;
					end else begin
						walk_idx_d = walk_idx_q + CNT_W'(1);
						rd_en      = 1'b1;
						rd_addr    = walk_next;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			walk_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			front_q    <= front_d;
			count_q    <= count_d;
			walk_idx_q <= walk_idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// store and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[front_dec] <= op.value;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			walk_ptr_q <= rd_addr;
		end
		if (emit) begin
			out_q <= emit_rsp;
		end
	end

	assign response.valid   = out_valid_q;
	assign response.payload = out_q;
endmodule

// File: test/bounded_deque_head_push_tb.sv
// self-checking testbench of the bounded deque: scoreboard class, stimulus tasks and checks
`timescale 1ns / 100ps

module bounded_deque_head_push_tb;
	import bdq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 7;
	// long hold-off on the result side so that the block fills and stalls its input
	localparam int HOLD_CYCLES    = 150;
	// longest run of cycles with no transfer on either channel before giving up
	localparam int WATCHDOG_LIMIT = 2000;
	// cycles left after the last expected result, to catch stray results
	localparam int END_CYCLES     = 20;
	localparam int MAX_PRINTED    = 40;

	// scoreboard: tracks the list contents and the results still owed by the block
	class deque_scoreboard;
		logic signed [VAL_W-1:0] slots [DEPTH];
		int   head;
		int   count;
		rsp_t owed [$];
		int   errors;
		int   results_seen;

		function new();
			head         = 0;
			count        = 0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void queue_result(logic signed [VAL_W-1:0] data, logic [ST_W-1:0] status,
			logic last);
			rsp_t r;
			r.data_out = data;
			r.status   = status;
			r.entries  = CNT_W'(count);
			r.last     = last;
			owed.push_back(r);
		endfunction

		// work out what one accepted command must produce, and update the list
		function void note_request(req_t req);
			logic signed [VAL_W-1:0] data;
			case (req.command)
				CMD_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						queue_result('0, ST_FULL, 1'b1);
					end else begin
						head        = (head + DEPTH - 1) % DEPTH;
						slots[head] = req.value;
						count++;
						queue_result('0, ST_OK, 1'b1);
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK: begin
					if (count == 0) begin
						queue_result('0, ST_EMPTY, 1'b1);
					end else begin
						if (req.command == CMD_POP_FRONT) begin
							data = slots[head];
							head = (head + 1) % DEPTH;
						end else begin
							data = slots[(head + count - 1) % DEPTH];
						end
						count--;
						queue_result(data, ST_OK, 1'b1);
					end
				end
				CMD_WALK: begin
					if (count == 0) begin
						queue_result('0, ST_EMPTY, 1'b1);
					end else begin
						for (int i = 0; i < count; i++)
							queue_result(slots[(head + i) % DEPTH], ST_OK, i == count - 1);
					end
				end
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch: %s", msg);
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			results_seen++;
			if (owed.size() == 0) begin
				report($sformatf("result %0d with nothing outstanding: data %0d status %0d",
					results_seen, got.data_out, got.status));
				return;
			end
			want = owed.pop_front();
			if (got.data_out !== want.data_out)
				report($sformatf("result %0d data_out %0d, want %0d",
					results_seen, got.data_out, want.data_out));
			if (got.status !== want.status)
				report($sformatf("result %0d status %0d, want %0d",
					results_seen, got.status, want.status));
			if (got.entries !== want.entries)
				report($sformatf("result %0d entries %0d, want %0d",
					results_seen, got.entries, want.entries));
			if (got.last !== want.last)
				report($sformatf("result %0d last %0d, want %0d",
					results_seen, got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	bdq_stream_if #(.payload_t(req_t)) request_ch ();
	bdq_stream_if #(.payload_t(rsp_t)) response_ch ();

	bounded_deque_head_push #(
		.DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch.sink),
		.response(response_ch.source)
	);

	deque_scoreboard board = new();

	// idling controls, changed between phases by the stimulus process
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_start     = 1'b0;
	int idle_cycles    = 0;

	initial begin
		clk = 1'b0;
	end

	always #(HALF_PERIOD) clk = ~clk;

	// result side: random stalls, plus the long hold-off counted here in its own loop
	initial begin
		int hold_left;
		hold_left         = 0;
		response_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_left  = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				response_ch.ready = 1'b0;
				hold_left--;
			end else begin
				response_ch.ready = arst_n && ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// every result transfer is checked against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && response_ch.valid && response_ch.ready)
			board.check_response(response_ch.payload);
	end

	// watchdog: a long stretch with no transfer on either side means the block is stuck
	always @(posedge clk) begin
		if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one command, called at a falling edge, returns at the falling edge after the
	// transfer; valid stays high between back-to-back commands
	task automatic send_request(input logic [CMD_W-1:0] command,
		input logic signed [VAL_W-1:0] value);
		req_t req;
		req.command = command;
		req.value   = value;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			request_ch.valid = 1'b0;
			@(negedge clk);
		end
		request_ch.valid   = 1'b1;
		request_ch.payload = req;
		do
			@(posedge clk);
		while (!request_ch.ready);
		board.note_request(req);
		@(negedge clk);
	endtask

	// random commands with a chosen mix; pops go to either end with equal odds
	task automatic run_random(input int items, input int push_pct, input int walk_pct);
		int                      roll;
		logic [CMD_W-1:0]        command;
		logic signed [VAL_W-1:0] value;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(99);
			if (roll < push_pct)
				command = CMD_PUSH_FRONT;
			else if (roll < push_pct + walk_pct)
				command = CMD_WALK;
			else if ($urandom_range(1) == 0)
				command = CMD_POP_FRONT;
			else
				command = CMD_POP_BACK;
			value = $urandom();
			// now and then an extreme value
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: value = 32'sh7fff_ffff;
					1: value = 32'sh8000_0000;
					2: value = '0;
					default: value = '1;
				endcase
			end
			send_request(command, value);
		end
	endtask

	initial begin
		// all inputs known from time zero, reset held low before the first command
		arst_n             = 1'b0;
		request_ch.valid   = 1'b0;
		request_ch.payload = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list on each pop and on a walk
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_POP_BACK, '0);
		send_request(CMD_WALK, '0);
		// a single element leaves from the front, then from the back
		send_request(CMD_PUSH_FRONT, 32'sd5);
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_PUSH_FRONT, 32'sd7);
		send_request(CMD_POP_BACK, '0);
		// extremes of the value, then walk them front to back
		send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
		send_request(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_request(CMD_PUSH_FRONT, '0);
		send_request(CMD_PUSH_FRONT, '1);
		send_request(CMD_WALK, '0);
		send_request(CMD_POP_BACK, '0);
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_WALK, '0);
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_POP_BACK, '0);
		// alternating bit patterns, drained past empty from the back
		send_request(CMD_PUSH_FRONT, 32'sh5555_5555);
		send_request(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
		send_request(CMD_WALK, '0);
		send_request(CMD_POP_BACK, '0);
		send_request(CMD_POP_BACK, '0);
		send_request(CMD_POP_BACK, '0);

		// random, no idling on either side
		run_random(80, 50, 10);

		// pressure: result side held off while commands keep coming
		hold_start = 1'b1;
		run_random(40, 70, 10);

		// sender mostly idle, push-heavy so the list fills and pushes get dropped
		send_idle_pct = 82;
		run_random(90, 90, 5);

		// receiver mostly stalling, walks of a long list back up the result side
		send_idle_pct  = 0;
		recv_stall_pct = 82;
		run_random(80, 45, 15);

		// both sides idling, pop-heavy so the list drains to empty
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		run_random(100, 15, 10);

		request_ch.valid = 1'b0;

		// wait for every owed result, then let the clock run on to catch strays
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_stream_if.sv
rtl/core/bdq_front.sv
rtl/core/bdq_queue.sv
rtl/core/bdq_back.sv
rtl/core/bounded_deque_head_push.sv
test/bounded_deque_head_push_tb.sv
